@@ hw/rtl/b2n_pkg.sv @@
package b2n_pkg;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // bt.601 studio range coefficients, 8 fractional bits
  localparam int Y_R   = 66;
  localparam int Y_G   = 129;
  localparam int Y_B   = 25;
  localparam int CB_R  = 38;
  localparam int CB_G  = 74;
  localparam int CB_B  = 112;
  localparam int CR_R  = 112;
  localparam int CR_G  = 94;
  localparam int CR_B  = 18;
  localparam int ROUND = 128;
  localparam int Y_OFS = 16;
  // chroma offset of 128 folded in before the shift
  localparam int C_BIAS = 128 * 256;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       end_of_frame;
  } result_t;

  // two-pixel channel sums of one column pair
  typedef struct packed {
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } pair_sum_t;

  // per-word info handed from the position tracker to the color pipe
  typedef struct packed {
    pixel_t    pixel;
    pair_sum_t pair_sum;
    logic      chroma;
    logic      eof;
  } front_info_t;

endpackage

@@ hw/rtl/b2n_line_store.sv @@
module b2n_line_store #(
  parameter int DEPTH = b2n_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = $clog2(b2n_pkg::MAX_WIDTH_DEF) - 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic                rd_en,
  input  logic [AW-1:0]       addr,
  input  b2n_pkg::pair_sum_t  wr_data,
  output b2n_pkg::pair_sum_t  rd_data
);
  import b2n_pkg::*;

  pair_sum_t mem [DEPTH];
  pair_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/b2n_front.sv @@
module b2n_front #(
  parameter int MAX_WIDTH  = b2n_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = b2n_pkg::MAX_HEIGHT_DEF,
  localparam int AW        = $clog2(MAX_WIDTH) - 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [b2n_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [b2n_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          accept,
  input  b2n_pkg::pixel_t               pixel,
  output b2n_pkg::front_info_t          info,
  output logic                          wr_en,
  output logic                          rd_en,
  output logic [AW-1:0]                 addr
);
  import b2n_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int W_LIMIT = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int H_LIMIT = MAX_HEIGHT - (MAX_HEIGHT % 2);

  logic [CFG_W-1:0] line_width_r, frame_height_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  pixel_t           held_r;
  logic [CFG_W-1:0] w_even, h_even;
  logic [CW:0]      w_eff;
  logic [RW:0]      h_eff;
  logic             last_col, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // even sizes, zero acts as 2, capped at the store limits
  assign w_even = {line_width_r[CFG_W-1:1], 1'b0};
  assign h_even = {frame_height_r[CFG_W-1:1], 1'b0};

  always_comb begin
    if (w_even == '0) begin
      w_eff = (CW+1)'(2);
    end else if (32'(w_even) > W_LIMIT) begin
      w_eff = (CW+1)'(W_LIMIT);
    end else begin
      w_eff = (CW+1)'(w_even);
    end
    if (h_even == '0) begin
      h_eff = (RW+1)'(2);
    end else if (32'(h_even) > H_LIMIT) begin
      h_eff = (RW+1)'(H_LIMIT);
    end else begin
      h_eff = (RW+1)'(h_even);
    end
  end

  assign last_col = ({1'b0, col_r} + (CW+1)'(1)) >= w_eff;
  assign last_row = ({1'b0, row_r} + (RW+1)'(1)) >= h_eff;

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!col_r[0]) begin
        held_r <= pixel;
      end
    end
  end

  always_comb begin
    info.pixel          = pixel;
    info.pair_sum.blue  = 9'(pixel.blue)  + 9'(held_r.blue);
    info.pair_sum.green = 9'(pixel.green) + 9'(held_r.green);
    info.pair_sum.red   = 9'(pixel.red)   + 9'(held_r.red);
    info.chroma         = col_r[0] & row_r[0];
    info.eof            = last_col & last_row;
  end

  assign wr_en = accept & col_r[0] & ~row_r[0];
  assign rd_en = accept & col_r[0] & row_r[0];
  assign addr  = col_r[CW-1:1];

  a_eof_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && info.eof |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap at end of frame");

  a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last_col |=> col_r == $past(col_r) + CW'(1) && row_r == $past(row_r))
    else $error("column counter did not step");

endmodule

@@ hw/rtl/b2n_color.sv @@
module b2n_color (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b2n_pkg::front_info_t info,
  input  b2n_pkg::pair_sum_t   line_entry,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b2n_pkg::result_t     out_data
);
  import b2n_pkg::*;

  logic        s1_valid_r, s2_valid_r, out_valid_r;
  front_info_t s1_info_r;
  logic [7:0]  s2_luma_r;
  pixel_t      s2_avg_r;
  logic        s2_chroma_r, s2_eof_r;
  result_t     out_data_r;

  logic        out_free, s2_free, s1_free;
  logic [16:0] y_sum;
  logic [8:0]  y_ofs;
  logic [9:0]  tot_b, tot_g, tot_r;
  logic [16:0] cb_sum, cr_sum;
  logic [7:0]  cb_val, cr_val;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  // stage 1: word plus line entry read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_info_r <= info;
    end
  end

  // stage 2: luma and the four-pixel averages
  always_comb begin
    y_sum = 17'(s1_info_r.pixel.red) * 17'(Y_R) + 17'(s1_info_r.pixel.green) * 17'(Y_G)
          + 17'(s1_info_r.pixel.blue) * 17'(Y_B) + 17'(ROUND);
    y_ofs = y_sum[16:8] + 9'(Y_OFS);
    tot_b = 10'(s1_info_r.pair_sum.blue)  + 10'(line_entry.blue);
    tot_g = 10'(s1_info_r.pair_sum.green) + 10'(line_entry.green);
    tot_r = 10'(s1_info_r.pair_sum.red)   + 10'(line_entry.red);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      s2_luma_r      <= (y_ofs > 9'd255) ? 8'hFF : y_ofs[7:0];
      s2_avg_r.blue  <= tot_b[9:2];
      s2_avg_r.green <= tot_g[9:2];
      s2_avg_r.red   <= tot_r[9:2];
      s2_chroma_r    <= s1_info_r.chroma;
      s2_eof_r       <= s1_info_r.eof;
    end
  end

  // stage 3: chroma; with the offset added first the sums stay positive
  always_comb begin
    cb_sum = 17'(s2_avg_r.blue) * 17'(CB_B) + 17'(C_BIAS + ROUND)
           - 17'(s2_avg_r.red) * 17'(CB_R) - 17'(s2_avg_r.green) * 17'(CB_G);
    cr_sum = 17'(s2_avg_r.red) * 17'(CR_R) + 17'(C_BIAS + ROUND)
           - 17'(s2_avg_r.green) * 17'(CR_G) - 17'(s2_avg_r.blue) * 17'(CR_B);
    cb_val = cb_sum[16] ? 8'hFF : cb_sum[15:8];
    cr_val = cr_sum[16] ? 8'hFF : cr_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid_r) begin
      out_data_r.luma         <= s2_luma_r;
      out_data_r.chroma_valid <= s2_chroma_r;
      out_data_r.cb           <= s2_chroma_r ? cb_val : 8'd0;
      out_data_r.cr           <= s2_chroma_r ? cr_val : 8'd0;
      out_data_r.end_of_frame <= s2_eof_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.luma >= 8'd16 && out_data.luma <= 8'd235)
    else $error("luma outside studio range");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chroma_valid |->
      out_data.cb >= 8'd16 && out_data.cb <= 8'd240 &&
      out_data.cr >= 8'd16 && out_data.cr <= 8'd240)
    else $error("chroma outside studio range");

  a_chroma_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chroma_valid |-> out_data.cb == 8'd0 && out_data.cr == 8'd0)
    else $error("chroma not cleared without a completed block");

endmodule

@@ hw/rtl/bgra_to_nv12_converter_core.sv @@
// bt.601 studio-range bgra to ycbcr 4:2:0 converter in nv12 sample order. pixels enter
// one word per clock in raster order while in_ready is high; every word gives one result
// word: the pixel's luma, and at the odd column of an odd row the cb/cr of the finished
// 2x2 block, with chroma_valid set. the sustained rate is one word per clock while
// out_ready stays high; a word passes three register stages (line store read,
// luma/average stage, chroma stage) before out_valid rises. the pair sums of even rows
// live in a line store of MAX_WIDTH/2 entries with one write or one registered read per
// clock; the store has no reset and no clearing pass,
// so the first odd row of a frame must follow an even row of the same width. frame size
// comes from line_width (index 0) and frame_height (index 1); the low bit of each is
// ignored, zero acts as 2 and values beyond MAX_WIDTH/MAX_HEIGHT are capped. write the
// size registers only while the block is idle.
module bgra_to_nv12_converter_core #(
  parameter int MAX_WIDTH  = b2n_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = b2n_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  b2n_pkg::pixel_t               in_data,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output b2n_pkg::result_t              out_data,
  // size registers
  input  logic                          cfg_we,
  input  logic [b2n_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [b2n_pkg::CFG_W-1:0]     cfg_wdata
);
  import b2n_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(MAX_WIDTH) - 1;

  logic        accept;
  front_info_t info;
  logic        wr_en, rd_en;
  logic [AW-1:0] addr;
  pair_sum_t   line_entry;

  // a word is taken whenever one is offered and stage 1 is free
  assign accept = in_valid && in_ready;

  // position counters, held even-column pixel and store access
  b2n_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .pixel    (in_data),
    .info     (info),
    .wr_en    (wr_en),
    .rd_en    (rd_en),
    .addr     (addr)
  );

  // even rows write a slot, the odd row below reads it at least two words later,
  // so a read never meets a write to the same slot in one clock
  b2n_line_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .rd_en  (rd_en),
    .addr   (addr),
    .wr_data(info.pair_sum),
    .rd_data(line_entry)
  );

  // three-stage elastic pipe; each stage fills while the one after it stalls
  b2n_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .info      (info),
    .line_entry(line_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
